// File: rtl/olda_pkg.sv
// Package for the one-lane direction arbiter: shared types, result codes and limits.
// Used by the step unit, the top level and the testbench.
`default_nettype none

package olda_pkg;

   localparam int unsigned CountWidth = 6;
   localparam int unsigned QueueWidth = 8;
   localparam int unsigned RunWidth   = 7;
   localparam int unsigned KindWidth  = 3;
   localparam int unsigned CsrWidth   = 7;

   localparam logic [CountWidth-1:0] CapHw  = 6'd32;
   localparam logic [QueueWidth-1:0] QueueHw = 8'd255;
   localparam logic [RunWidth-1:0]   RunMax = 7'd127;

   localparam logic [CountWidth-1:0] CapacityReset   = 6'd4;
   localparam logic [RunWidth-1:0]   BatchLimitReset = 7'd8;

   typedef enum logic [0:0] {
      CSR_CAPACITY    = 1'b0,
      CSR_BATCH_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      MODE_ARRIVE = 1'b0,
      MODE_DEPART = 1'b1
   } mode_type;

   typedef enum logic [KindWidth-1:0] {
      KIND_ENTERED  = 3'd0,
      KIND_QUEUED   = 3'd1,
      KIND_DEPARTED = 3'd2,
      KIND_ADMITTED = 3'd3,
      KIND_ERROR    = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      OP_ARRIVE,
      OP_DEPART,
      OP_ADMIT
   } op_type;

   typedef struct packed {
      logic [1:0][CountWidth-1:0] occupancy;
      logic [1:0][QueueWidth-1:0] waiting;
      logic [RunWidth-1:0]        run_length;
   } arb_state_type;

   typedef struct packed {
      kind_type kind;
      logic     side;
      logic     more;
      logic     admit_side;
   } step_out_type;

endpackage

`default_nettype wire

// File: rtl/olda_req_if.sv
// Request channel of the one-lane direction arbiter: valid/ready handshake and event fields.
// Depends on nothing else.
`default_nettype none

interface olda_req_if;
   logic valid;
   logic ready;
   logic mode;
   logic side;

   modport source (output valid, output mode, output side, input ready);
   modport sink (input valid, input mode, input side, output ready);
endinterface

`default_nettype wire

// File: rtl/olda_rsp_if.sv
// Response channel of the one-lane direction arbiter: valid/ready handshake and result fields.
// Depends on nothing else.
`default_nettype none

interface olda_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic       granted_side;
   logic [5:0] blue_inside;
   logic [5:0] red_inside;
   logic       last;

   modport source (output valid, output kind, output granted_side, output blue_inside,
                   output red_inside, output last, input ready);
   modport sink (input valid, input kind, input granted_side, input blue_inside,
                 input red_inside, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/olda_step.sv
// Shared step unit: applies one arrival, departure or admission to the arbiter state.
// Depends on olda_pkg.
`default_nettype none

module olda_step
   import olda_pkg::*;
(
   input  op_type                  op,
   input  logic                    side,
   input  arb_state_type           cur,
   input  logic [CountWidth-1:0]   cap,
   input  logic [RunWidth-1:0]     batch_limit,
   input  logic [QueueWidth-1:0]   queue_limit,
   output arb_state_type           nxt,
   output step_out_type            res
);

   logic           o;
   logic           chk;
   logic           force_more;
   logic           force_side;
   logic           follow;
   kind_type       kind;
   logic [RunWidth-1:0] run_bumped;

   assign o = ~side;
   assign run_bumped = (cur.run_length < RunMax) ? cur.run_length + 7'd1 : cur.run_length;

   always_comb begin
      nxt        = cur;
      kind       = KIND_ERROR;
      chk        = 1'b0;
      force_more = 1'b0;
      force_side = side;
      unique case (op)
         OP_ARRIVE: begin
            if (cur.occupancy[o] != '0 || cur.occupancy[side] >= cap ||
                cur.run_length >= batch_limit) begin
               if (cur.waiting[side] >= queue_limit) begin
                  kind = KIND_ERROR;
               end else begin
                  nxt.waiting[side] = cur.waiting[side] + 8'd1;
                  kind = KIND_QUEUED;
               end
            end else begin
               nxt.occupancy[side] = cur.occupancy[side] + 6'd1;
               nxt.run_length      = run_bumped;
               kind                = KIND_ENTERED;
               chk                 = 1'b1;
            end
         end
         OP_DEPART: begin
            if (cur.occupancy[side] == '0) begin
               kind = KIND_ERROR;
            end else begin
               nxt.occupancy[side] = cur.occupancy[side] - 6'd1;
               kind                = KIND_DEPARTED;
               if (cur.waiting[side] != '0 && nxt.occupancy[side] < cap &&
                   (cur.run_length < batch_limit || cur.waiting[o] == '0)) begin
                  force_more = 1'b1;
               end else if (cur.waiting[o] != '0 && nxt.occupancy[side] == '0) begin
                  nxt.run_length = '0;
                  force_more     = 1'b1;
                  force_side     = o;
               end else if (cur.waiting[0] == '0 && cur.waiting[1] == '0) begin
                  nxt.run_length = '0;
               end
            end
         end
         OP_ADMIT: begin
            nxt.waiting[side]   = cur.waiting[side] - 8'd1;
            nxt.occupancy[side] = cur.occupancy[side] + 6'd1;
            nxt.run_length      = run_bumped;
            kind                = KIND_ADMITTED;
            chk                 = 1'b1;
         end
         default: begin
            kind = KIND_ERROR;
         end
      endcase
   end

   assign follow = nxt.waiting[side] != '0 && nxt.occupancy[side] < cap &&
                   nxt.run_length < batch_limit;

   assign res = {kind, side, force_more | (chk & follow), force_side};

endmodule

`default_nettype wire

// File: rtl/one_lane_direction_arbiter_core.sv
// Top level of the one-lane direction arbiter: sequencer, state, registers and response stage.
// Depends on olda_pkg, olda_req_if, olda_rsp_if and olda_step.
`default_nettype none

// The arbiter lets blue and red users share one resource, one class at a time, at most
// capacity users at once, and yields to the other class after batch_limit admissions in a
// row. Each request gives one response for the event, then one response per waiting user
// admitted in the cascade that follows; last marks the final one. A request is accepted in
// ST_IDLE, then each response passes through ST_STEP, where the shared step unit computes
// it, and ST_SEND, where the response register holds it until it is taken. A new request
// is accepted only after the last response has been taken.
module one_lane_direction_arbiter_core
   import olda_pkg::*;
#(
   parameter int unsigned MAX_WAITING = 255
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   olda_req_if.sink                   req_ch,
   olda_rsp_if.source                 rsp_ch,
   input  wire logic                  csr_we,
   input  wire logic                  csr_index,
   input  wire logic [CsrWidth-1:0]   csr_wdata
);

   localparam logic [QueueWidth-1:0] QueueLimit =
      (MAX_WAITING > 255) ? QueueHw : QueueWidth'(MAX_WAITING);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_STEP = 3'b010,
      ST_SEND = 3'b100
   } seq_state_type;

   seq_state_type         seq_ff, seq_in;
   arb_state_type         arb_ff, arb_in;
   logic [CountWidth-1:0] capacity_ff;
   logic [RunWidth-1:0]   batch_limit_ff;
   op_type                op_ff, op_in;
   logic                  side_ff, side_in;
   logic                  more_ff, more_in;
   kind_type              kind_ff, kind_in;
   logic                  gside_ff, gside_in;
   logic                  last_ff, last_in;
   logic [CountWidth-1:0] cap_eff;
   arb_state_type         step_nxt;
   step_out_type          step_res;

   assign cap_eff = (capacity_ff > CapHw) ? CapHw : capacity_ff;

   olda_step u_step (
      .op          (op_ff),
      .side        (side_ff),
      .cur         (arb_ff),
      .cap         (cap_eff),
      .batch_limit (batch_limit_ff),
      .queue_limit (QueueLimit),
      .nxt         (step_nxt),
      .res         (step_res)
   );

   always_comb begin
      seq_in   = seq_ff;
      arb_in   = arb_ff;
      op_in    = op_ff;
      side_in  = side_ff;
      more_in  = more_ff;
      kind_in  = kind_ff;
      gside_in = gside_ff;
      last_in  = last_ff;
      unique case (seq_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               op_in   = (req_ch.mode == MODE_DEPART) ? OP_DEPART : OP_ARRIVE;
               side_in = req_ch.side;
               seq_in  = ST_STEP;
            end
         end
         ST_STEP: begin
            arb_in   = step_nxt;
            kind_in  = step_res.kind;
            gside_in = step_res.side;
            last_in  = ~step_res.more;
            more_in  = step_res.more;
            op_in    = OP_ADMIT;
            side_in  = step_res.admit_side;
            seq_in   = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_ch.ready) begin
               seq_in = more_ff ? ST_STEP : ST_IDLE;
            end
         end
         default: begin
            seq_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff         <= ST_IDLE;
         arb_ff         <= '0;
         capacity_ff    <= CapacityReset;
         batch_limit_ff <= BatchLimitReset;
         more_ff        <= 1'b0;
      end else begin
         seq_ff  <= seq_in;
         arb_ff  <= arb_in;
         more_ff <= more_in;
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_CAPACITY:    capacity_ff    <= csr_wdata[CountWidth-1:0];
               CSR_BATCH_LIMIT: batch_limit_ff <= csr_wdata[RunWidth-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      side_ff  <= side_in;
      kind_ff  <= kind_in;
      gside_ff <= gside_in;
      last_ff  <= last_in;
   end

   assign req_ch.ready        = (seq_ff == ST_IDLE);
   assign rsp_ch.valid        = (seq_ff == ST_SEND);
   assign rsp_ch.kind         = kind_ff;
   assign rsp_ch.granted_side = gside_ff;
   assign rsp_ch.blue_inside  = arb_ff.occupancy[0];
   assign rsp_ch.red_inside   = arb_ff.occupancy[1];
   assign rsp_ch.last         = last_ff;

   a_one_class_inside: assert property (@(posedge clock) disable iff (reset)
      !(arb_ff.occupancy[0] != '0 && arb_ff.occupancy[1] != '0))
      else $error("both classes occupy the resource");

   a_inside_bounded: assert property (@(posedge clock) disable iff (reset)
      arb_ff.occupancy[0] <= CapHw && arb_ff.occupancy[1] <= CapHw)
      else $error("occupancy above hardware capacity");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_ch.valid && req_ch.ready))
      else $error("request accepted while a response is pending");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.ready && rsp_ch.last |=> req_ch.ready)
      else $error("sequencer did not return to idle after the last response");

   a_more_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.ready && !rsp_ch.last |=> !req_ch.ready && !rsp_ch.valid)
      else $error("cascade response sequence broken");

endmodule

`default_nettype wire

// File: verif/tb_one_lane_direction_arbiter_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for one_lane_direction_arbiter_core: a directed table, then random
// arrive/depart traffic under several capacity and batch settings, checked by a local predictor.
// Depends on olda_pkg, olda_req_if, olda_rsp_if and the RTL of the arbiter.

module tb_one_lane_direction_arbiter_core;
   import olda_pkg::*;

   localparam int unsigned MaxWaiting     = 255;
   localparam int unsigned WaitingLimit   = (MaxWaiting > 255) ? 255 : MaxWaiting;
   localparam int unsigned DrainCycles    = 8;
   localparam int unsigned LongHoldCycles = 200;
   localparam logic        SideBlue       = 1'b0;
   localparam logic        SideRed        = 1'b1;

   typedef enum logic {
      ROW_REQ,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      row_kind_type         what;
      mode_type             mode;
      logic                 side;
      logic                 typed;
      kind_type             kind;
      csr_index_type        index;
      logic [CsrWidth-1:0]  value;
   } stim_row_type;

   typedef struct {
      kind_type               kind;
      logic                   side;
      logic [CountWidth-1:0]  blue;
      logic [CountWidth-1:0]  red;
      logic                   last;
   } result_type;

   localparam stim_row_type DirectedRows [0:28] = '{
      '{ROW_REQ, MODE_DEPART, SideBlue, 1'b1, KIND_ERROR,   CSR_CAPACITY,    7'd0},
      '{ROW_REQ, MODE_DEPART, SideRed,  1'b1, KIND_ERROR,   CSR_CAPACITY,    7'd0},
      '{ROW_REQ, MODE_ARRIVE, SideBlue, 1'b1, KIND_ENTERED, CSR_CAPACITY,    7'd0},
      '{ROW_REQ, MODE_ARRIVE, SideRed,  1'b1, KIND_QUEUED,  CSR_CAPACITY,    7'd0},
      '{ROW_REQ, MODE_ARRIVE, SideBlue, 1'b0, KIND_ENTERED, CSR_CAPACITY,    7'd0},
      '{ROW_REQ, MODE_ARRIVE, SideBlue, 1'b0, KIND_ENTERED, CSR_CAPACITY,    7'd0},
      '{ROW_REQ, MODE_ARRIVE, SideBlue, 1'b0, KIND_ENTERED, CSR_CAPACITY,    7'd0},
      '{ROW_REQ, MODE_ARRIVE, SideBlue, 1'b0, KIND_ENTERED, CSR_CAPACITY,    7'd0},
      '{ROW_REQ, MODE_DEPART, SideBlue, 1'b0, KIND_ENTERED, CSR_CAPACITY,    7'd0},
      '{ROW_REQ, MODE_DEPART, SideBlue, 1'b0, KIND_ENTERED, CSR_CAPACITY,    7'd0},
      '{ROW_REQ, MODE_DEPART, SideBlue, 1'b0, KIND_ENTERED, CSR_CAPACITY,    7'd0},
      '{ROW_REQ, MODE_DEPART, SideBlue, 1'b0, KIND_ENTERED, CSR_CAPACITY,    7'd0},
      '{ROW_REQ, MODE_DEPART, SideBlue, 1'b0, KIND_ENTERED, CSR_CAPACITY,    7'd0},
      '{ROW_REQ, MODE_DEPART, SideRed,  1'b0, KIND_ENTERED, CSR_CAPACITY,    7'd0},
      '{ROW_CSR, MODE_ARRIVE, SideBlue, 1'b0, KIND_ENTERED, CSR_CAPACITY,    7'd0},
      '{ROW_REQ, MODE_ARRIVE, SideRed,  1'b1, KIND_QUEUED,  CSR_CAPACITY,    7'd0},
      '{ROW_REQ, MODE_ARRIVE, SideBlue, 1'b1, KIND_QUEUED,  CSR_CAPACITY,    7'd0},
      '{ROW_REQ, MODE_DEPART, SideRed,  1'b1, KIND_ERROR,   CSR_CAPACITY,    7'd0},
      '{ROW_CSR, MODE_ARRIVE, SideBlue, 1'b0, KIND_ENTERED, CSR_CAPACITY,    7'd63},
      '{ROW_CSR, MODE_ARRIVE, SideBlue, 1'b0, KIND_ENTERED, CSR_BATCH_LIMIT, 7'd0},
      '{ROW_REQ, MODE_ARRIVE, SideBlue, 1'b1, KIND_QUEUED,  CSR_CAPACITY,    7'd0},
      '{ROW_CSR, MODE_ARRIVE, SideBlue, 1'b0, KIND_ENTERED, CSR_BATCH_LIMIT, 7'd127},
      '{ROW_REQ, MODE_ARRIVE, SideRed,  1'b0, KIND_ENTERED, CSR_CAPACITY,    7'd0},
      '{ROW_REQ, MODE_DEPART, SideRed,  1'b0, KIND_ENTERED, CSR_CAPACITY,    7'd0},
      '{ROW_REQ, MODE_DEPART, SideRed,  1'b0, KIND_ENTERED, CSR_CAPACITY,    7'd0},
      '{ROW_REQ, MODE_DEPART, SideBlue, 1'b0, KIND_ENTERED, CSR_CAPACITY,    7'd0},
      '{ROW_REQ, MODE_DEPART, SideBlue, 1'b0, KIND_ENTERED, CSR_CAPACITY,    7'd0},
      '{ROW_REQ, MODE_ARRIVE, SideRed,  1'b0, KIND_ENTERED, CSR_CAPACITY,    7'd0},
      '{ROW_REQ, MODE_DEPART, SideRed,  1'b0, KIND_ENTERED, CSR_CAPACITY,    7'd0}
   };

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic                 csr_index = CSR_CAPACITY;
   logic [CsrWidth-1:0]  csr_wdata = '0;

   olda_req_if req_bus();
   olda_rsp_if rsp_bus();

   // Predicted state of the arbiter and its registers.
   logic [CountWidth-1:0] occupancy [2];
   logic [QueueWidth-1:0] waiting_len [2];
   logic [RunWidth-1:0]   run_len;
   logic [CountWidth-1:0] cap_reg;
   logic [RunWidth-1:0]   batch_reg;

   result_type pending_results [$];
   result_type want;
   int         failures = 0;
   int         sent_count = 0;
   bit         sender_steady = 1'b0;
   bit         long_hold_due = 1'b0;
   bit         rsp_steady = 1'b0;
   int         stall_left = 0;
   int         stretch_left = 0;

   one_lane_direction_arbiter_core #(
      .MAX_WAITING(MaxWaiting)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_ch(req_bus),
      .rsp_ch(rsp_bus),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      #20ms;
      $display("one_lane_direction_arbiter_core regression: fail");
      $finish;
   end

   function automatic int unsigned seat_limit();
      return (cap_reg > CapHw) ? CapHw : cap_reg;
   endfunction

   function automatic void bump_run();
      if (run_len < RunMax) run_len = run_len + 1'b1;
   endfunction

   function automatic void note_result(kind_type k, logic s);
      result_type r;
      r.kind = k;
      r.side = s;
      r.blue = occupancy[0];
      r.red = occupancy[1];
      r.last = 1'b0;
      pending_results.push_back(r);
   endfunction

   function automatic void admit_one(logic s);
      waiting_len[s] = waiting_len[s] - 1'b1;
      occupancy[s] = occupancy[s] + 1'b1;
      bump_run();
      note_result(KIND_ADMITTED, s);
   endfunction

   function automatic void admit_while_open(logic s);
      while (waiting_len[s] != 0 && occupancy[s] < seat_limit() && run_len < batch_reg)
         admit_one(s);
   endfunction

   function automatic void predict_event(mode_type m, logic s);
      logic o;
      o = ~s;
      if (m == MODE_ARRIVE) begin
         if (occupancy[o] != 0 || occupancy[s] >= seat_limit() || run_len >= batch_reg) begin
            if (waiting_len[s] >= WaitingLimit) begin
               note_result(KIND_ERROR, s);
            end else begin
               waiting_len[s] = waiting_len[s] + 1'b1;
               note_result(KIND_QUEUED, s);
            end
         end else begin
            occupancy[s] = occupancy[s] + 1'b1;
            bump_run();
            note_result(KIND_ENTERED, s);
            admit_while_open(s);
         end
      end else if (occupancy[s] == 0) begin
         note_result(KIND_ERROR, s);
      end else begin
         occupancy[s] = occupancy[s] - 1'b1;
         note_result(KIND_DEPARTED, s);
         if (waiting_len[s] != 0 && occupancy[s] < seat_limit() &&
             (run_len < batch_reg || waiting_len[o] == 0)) begin
            admit_one(s);
            admit_while_open(s);
         end else if (waiting_len[o] != 0 && occupancy[s] == 0) begin
            run_len = '0;
            admit_one(o);
            admit_while_open(o);
         end else if (waiting_len[0] == 0 && waiting_len[1] == 0) begin
            run_len = '0;
         end
      end
      pending_results[pending_results.size() - 1].last = 1'b1;
   endfunction

   function automatic logic occupied_side();
      if ($urandom_range(0, 9) == 0) return 1'($urandom_range(0, 1));
      if (occupancy[0] != 0) return SideBlue;
      if (occupancy[1] != 0) return SideRed;
      return 1'($urandom_range(0, 1));
   endfunction

   task automatic sender_gap();
      int n;
      n = 0;
      if (!sender_steady && $urandom_range(0, 99) < 30)
         n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
      if (n > 0) begin
         req_bus.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic offer_request(mode_type m, logic s, bit typed = 1'b0,
                                kind_type fixed_kind = KIND_ENTERED);
      int first;
      req_bus.valid <= 1'b1;
      req_bus.mode <= m;
      req_bus.side <= s;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      first = pending_results.size();
      predict_event(m, s);
      if (typed) pending_results[first].kind = fixed_kind;
      sent_count++;
      sender_gap();
   endtask

   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [CsrWidth-1:0] value);
      wait_for_drain();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      if (idx == CSR_CAPACITY) cap_reg = value[CountWidth-1:0];
      else batch_reg = value;
      csr_we <= 1'b0;
   endtask

   task automatic apply_settings(logic [CountWidth-1:0] cap, logic [RunWidth-1:0] batch);
      write_register(CSR_CAPACITY, {1'($urandom_range(0, 1)), cap});
      write_register(CSR_BATCH_LIMIT, batch);
      sender_steady = ($urandom_range(0, 3) == 0);
   endtask

   // Waves (one class in, the other queued behind, then the lane drains) or one random request.
   task automatic run_traffic(int budget, int max_queue);
      int stop_at;
      int n;
      int arrivals;
      logic s;
      stop_at = sent_count + budget;
      while (sent_count < stop_at) begin
         if ($urandom_range(0, 9) < 7) begin
            s = 1'($urandom_range(0, 1));
            n = $urandom_range(1, 4);
            arrivals = n;
            repeat (n) offer_request(MODE_ARRIVE, s);
            n = $urandom_range(0, max_queue);
            arrivals += n;
            repeat (n) offer_request(MODE_ARRIVE, ($urandom_range(0, 9) == 0) ? s : ~s);
            n = arrivals - 1 + $urandom_range(0, 2);
            repeat (n) offer_request(MODE_DEPART, occupied_side());
         end else begin
            offer_request(mode_type'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_results.size() == 0) begin
               $error("response with no request outstanding: kind %0d", rsp_bus.kind);
               failures++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_bus.kind !== want.kind) begin
                  $error("kind: expected %0d, actual %0d", want.kind, rsp_bus.kind);
                  failures++;
               end
               if (rsp_bus.granted_side !== want.side) begin
                  $error("granted_side: expected %0d, actual %0d", want.side,
                         rsp_bus.granted_side);
                  failures++;
               end
               if (rsp_bus.blue_inside !== want.blue) begin
                  $error("blue_inside: expected %0d, actual %0d", want.blue,
                         rsp_bus.blue_inside);
                  failures++;
               end
               if (rsp_bus.red_inside !== want.red) begin
                  $error("red_inside: expected %0d, actual %0d", want.red, rsp_bus.red_inside);
                  failures++;
               end
               if (rsp_bus.last !== want.last) begin
                  $error("last: expected %0d, actual %0d", want.last, rsp_bus.last);
                  failures++;
               end
            end
         end
         if (stretch_left == 0) begin
            stretch_left = $urandom_range(50, 300);
            rsp_steady = ($urandom_range(0, 2) == 0);
         end else begin
            stretch_left--;
         end
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            stall_left = LongHoldCycles;
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (!rsp_steady && $urandom_range(0, 99) < 30)
               stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(1, 3);
         end
      end
   end

   initial begin
      logic s;
      req_bus.valid <= 1'b0;
      req_bus.mode <= MODE_ARRIVE;
      req_bus.side <= SideBlue;
      occupancy[0] = '0;
      occupancy[1] = '0;
      waiting_len[0] = '0;
      waiting_len[1] = '0;
      run_len = '0;
      cap_reg = CapacityReset;
      batch_reg = BatchLimitReset;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < $size(DirectedRows); r++) begin
         if (DirectedRows[r].what == ROW_CSR) begin
            write_register(DirectedRows[r].index, DirectedRows[r].value);
         end else begin
            offer_request(DirectedRows[r].mode, DirectedRows[r].side, DirectedRows[r].typed,
                          DirectedRows[r].kind);
         end
      end

      // Batch limit zero queues every arrival; one class fills its queue, then gets errors.
      apply_settings(6'd3, 7'd0);
      s = 1'($urandom_range(0, 1));
      repeat (WaitingLimit + 2) offer_request(MODE_ARRIVE, s);

      // Under the widest settings the long queue fills the free seats, then one per departure.
      apply_settings(6'd63, 7'd127);
      offer_request(MODE_ARRIVE, s);
      repeat (24) offer_request(MODE_DEPART, occupied_side());

      apply_settings(6'd1, 7'd1);
      run_traffic(6, 3);
      apply_settings(6'd32, 7'd64);
      long_hold_due = 1'b1;
      run_traffic(10, 8);
      apply_settings(6'd0, 7'd3);
      run_traffic(4, 4);
      apply_settings(6'd5, 7'd0);
      run_traffic(4, 4);
      apply_settings(6'($urandom_range(1, 32)), 7'($urandom_range(1, 64)));
      run_traffic(6, 6);
      apply_settings(6'($urandom_range(1, 32)), 7'($urandom_range(1, 64)));
      run_traffic(4, 6);
      wait_for_drain();
      run_traffic(4, 6);
      apply_settings(6'($urandom_range(1, 32)), 7'($urandom_range(1, 64)));
      run_traffic(6, 6);

      wait_for_drain();
      if (failures == 0) begin
         $display("one_lane_direction_arbiter_core regression: pass");
      end else begin
         $display("one_lane_direction_arbiter_core regression: fail");
      end
      $finish;
   end

endmodule
